// ===== design/mqbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbr_pkg - shared definitions of the multi-queue byte ring engine
// Command and status codes, field widths and the job record that travels
// from the front to the back through the job queue.
// ----------------------------------------------------------------------------
package mqbr_pkg;

  // Defaults of the top-level parameters
  localparam int NUM_QUEUES_DEF      = 4;
  localparam int QUEUE_MEM_BYTES_DEF = 1024;
  localparam int MAX_POP_DEF         = 64;

  // Fixed field widths
  localparam int SIZE_REGS   = 4;   // size registers on the configuration port
  localparam int SIZE_W      = 10;  // queue size, index and fill width
  localparam int SUM_W       = 12;  // sum of all queue sizes
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 7;   // pop count width
  localparam int STAT_W      = 2;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;
  localparam int JOB_DEPTH   = 4;   // entries of the front-to-back job queue

  typedef logic [SIZE_W-1:0] qsize_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2,
    ST_OFF   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_NOTE  = 2'd0,  // result only, no store access
    JOB_WRITE = 2'd1,  // write one byte, then one result
    JOB_READ  = 2'd2   // read count bytes from start, one result each
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    status_t            status;
    logic [SIZE_W-1:0]  fill;
    logic [BYTE_W-1:0]  data;
    logic [SUM_W-1:0]   base;
    logic [SIZE_W-1:0]  start;
    logic [SIZE_W-1:0]  size;
    logic [CNT_W-1:0]   count;
  } job_t;

endpackage

// ===== design/multi_queue_byte_ring_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_byte_ring_engine_core - byte ring queues in one shared store
// Top level: size registers on the configuration port, front, job queue
// and back.
// ----------------------------------------------------------------------------
// Up to four byte ring queues share one byte store; each queue's region
// begins where the regions of the lower-numbered queues end, and a queue is
// usable only when its size is nonzero and its region ends below the store
// size. The front takes one command per cycle while the four-entry job queue
// has room, so in_stall rises only when the back has fallen behind. The back
// makes one store access per cycle through a single port unless a result is
// held by out_stall: push, peek, count and any rejected command produce one
// result each, and a successful pop of N bytes streams N results, the last
// marked by out_last. With nothing queued ahead, a command passes through the
// job queue and the back's result registers before out_valid rises. Writing
// any size register re-lays the store out and empties every queue; the store
// contents themselves are not cleared and there is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module multi_queue_byte_ring_engine_core #(
  parameter int NUM_QUEUES      = mqbr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_MEM_BYTES = mqbr_pkg::QUEUE_MEM_BYTES_DEF,
  parameter int MAX_POP         = mqbr_pkg::MAX_POP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [1:0]                    in_queue_id,
  input  logic [mqbr_pkg::BYTE_W-1:0]   in_push_byte,
  input  logic [mqbr_pkg::CNT_W-1:0]    in_pop_count,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mqbr_pkg::STAT_W-1:0]   out_status,
  output logic [mqbr_pkg::BYTE_W-1:0]   out_out_byte,
  output logic [mqbr_pkg::SIZE_W-1:0]   out_fill_count,
  output logic                          out_last,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mqbr_pkg::APB_AW-1:0]   paddr,
  input  logic [mqbr_pkg::APB_DW-1:0]   pwdata,
  output logic [mqbr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mqbr_pkg::*;

  qsize_t        size_r [SIZE_REGS];
  logic [1:0]    reg_idx;
  logic          wr_xfer, relayout;

  logic          job_full, job_push, job_pop, head_valid;
  job_t          front_job, head_job;

  // Register i sits at byte address 4*i. A write transfer completes in the
  // access phase; only registers of queues that exist take it.
  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign wr_xfer  = psel && penable && pwrite && pready;
  assign relayout = wr_xfer && (32'(reg_idx) < NUM_QUEUES);
  assign prdata   = APB_DW'(size_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SIZE_REGS; k++) begin
        size_r[k] <= '0;
      end
    end else if (relayout) begin
      size_r[reg_idx] <= pwdata[SIZE_W-1:0];
    end
  end

  mqbr_front #(
    .NUM_QUEUES      (NUM_QUEUES),
    .QUEUE_MEM_BYTES (QUEUE_MEM_BYTES),
    .MAX_POP         (MAX_POP)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_queue_id  (in_queue_id),
    .in_push_byte (in_push_byte),
    .in_pop_count (in_pop_count),
    .sizes        (size_r),
    .relayout     (relayout),
    .job_full     (job_full),
    .job_push     (job_push),
    .job          (front_job)
  );

  mqbr_job_fifo u_job_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (front_job),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mqbr_back #(
    .QUEUE_MEM_BYTES (QUEUE_MEM_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (head_valid),
    .job            (head_job),
    .job_pop        (job_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_out_byte   (out_out_byte),
    .out_fill_count (out_fill_count),
    .out_last       (out_last)
  );

endmodule

// ===== design/mqbr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbr_front - command classification and queue bookkeeping
// Takes one command a cycle while the job queue has room, updates the
// per-queue indices and fill, and hands a fully resolved job to the back.
// ----------------------------------------------------------------------------
module mqbr_front #(
  parameter int NUM_QUEUES      = mqbr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_MEM_BYTES = mqbr_pkg::QUEUE_MEM_BYTES_DEF,
  parameter int MAX_POP         = mqbr_pkg::MAX_POP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [1:0]                   in_queue_id,
  input  logic [mqbr_pkg::BYTE_W-1:0]  in_push_byte,
  input  logic [mqbr_pkg::CNT_W-1:0]   in_pop_count,
  input  mqbr_pkg::qsize_t             sizes [mqbr_pkg::SIZE_REGS],
  input  logic                         relayout,
  input  logic                         job_full,
  output logic                         job_push,
  output mqbr_pkg::job_t               job
);
  import mqbr_pkg::*;

  // Queue ids reach only the first SIZE_REGS queues.
  localparam int NQS = (NUM_QUEUES < SIZE_REGS) ? NUM_QUEUES : SIZE_REGS;
  localparam int QIW = (NQS > 1) ? $clog2(NQS) : 1;

  logic [SIZE_W-1:0] wr_r   [NQS];
  logic [SIZE_W-1:0] rd_r   [NQS];
  logic [SIZE_W-1:0] fill_r [NQS];

  logic [SIZE_W-1:0] wr_nxt, rd_nxt, fill_nxt;
  logic [SUM_W-1:0]  bases [SIZE_REGS];
  logic [SUM_W-1:0]  base;
  logic [SIZE_W-1:0] size, wr, rd, fill;
  logic [QIW-1:0]    qi;
  logic              q_ok, enabled, accept;
  logic [SIZE_W:0]   wr_inc, rd_inc, rd_adv;
  logic [31:0]       end_sum;

  assign in_stall = job_full;
  assign accept   = in_valid && !job_full;
  assign job_push = accept;

  // Region layout: each queue starts where the lower queues end.
  always_comb begin
    bases[0] = '0;
    for (int j = 1; j < SIZE_REGS; j++) begin
      bases[j] = bases[j-1] + SUM_W'(sizes[j-1]);
    end
  end

  assign qi      = QIW'(in_queue_id);
  assign q_ok    = 32'(in_queue_id) < NUM_QUEUES;
  assign base    = bases[in_queue_id];
  assign size    = sizes[in_queue_id];
  assign end_sum = 32'(base) + 32'(size);
  assign enabled = q_ok && (size != '0) && (end_sum < 32'(QUEUE_MEM_BYTES));
  assign wr      = wr_r[qi];
  assign rd      = rd_r[qi];
  assign fill    = fill_r[qi];
  assign wr_inc  = {1'b0, wr} + (SIZE_W+1)'(1);
  assign rd_inc  = {1'b0, rd} + (SIZE_W+1)'(1);
  assign rd_adv  = {1'b0, rd} + (SIZE_W+1)'(in_pop_count);

  always_comb begin
    job        = '0;
    job.kind   = JOB_NOTE;
    job.status = ST_OK;
    job.fill   = fill;
    job.data   = in_push_byte;
    job.base   = base;
    job.start  = rd;
    job.size   = size;
    job.count  = CNT_W'(1);
    wr_nxt     = wr;
    rd_nxt     = rd;
    fill_nxt   = fill;
    if (!enabled) begin
      job.status = ST_OFF;
      job.fill   = '0;
    end else begin
      unique case (cmd_t'(in_command))
        CMD_PUSH: begin
          job.kind  = JOB_WRITE;
          job.start = wr;
          wr_nxt    = (wr_inc == {1'b0, size}) ? '0 : wr_inc[SIZE_W-1:0];
          if (fill >= size) begin
            // Full: the oldest byte is dropped.
            rd_nxt   = (rd_inc == {1'b0, size}) ? '0 : rd_inc[SIZE_W-1:0];
            fill_nxt = size;
          end else begin
            fill_nxt = fill + SIZE_W'(1);
          end
          job.fill   = fill_nxt;
          job.status = (fill_nxt >= size) ? ST_FULL : ST_OK;
        end
        CMD_POP: begin
          if (in_pop_count == '0) begin
            job.status = ST_OK;
          end else if ((32'(in_pop_count) > MAX_POP) ||
                       (fill < SIZE_W'(in_pop_count))) begin
            job.status = ST_SHORT;
          end else begin
            job.kind  = JOB_READ;
            job.count = in_pop_count;
            fill_nxt  = fill - SIZE_W'(in_pop_count);
            job.fill  = fill_nxt;
            // The pop never exceeds the size, so one subtraction wraps it.
            rd_nxt    = (rd_adv >= {1'b0, size}) ? SIZE_W'(rd_adv - {1'b0, size})
                                                 : rd_adv[SIZE_W-1:0];
          end
        end
        CMD_PEEK: begin
          if (fill == '0) begin
            job.status = ST_SHORT;
            job.fill   = '0;
          end else begin
            job.kind = JOB_READ;
          end
        end
        CMD_COUNT: begin
          job.status = ST_OK;
        end
        default: begin
          job.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || relayout) begin
      for (int k = 0; k < NQS; k++) begin
        wr_r[k]   <= '0;
        rd_r[k]   <= '0;
        fill_r[k] <= '0;
      end
    end else if (accept && enabled) begin
      wr_r[qi]   <= wr_nxt;
      rd_r[qi]   <= rd_nxt;
      fill_r[qi] <= fill_nxt;
    end
  end

endmodule

// ===== design/mqbr_job_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbr_job_fifo - short job queue between front and back
// Holds resolved jobs in order so that each side can stall on its own.
// ----------------------------------------------------------------------------
module mqbr_job_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mqbr_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mqbr_pkg::job_t  head_job
);
  import mqbr_pkg::*;

  localparam int PW = $clog2(JOB_DEPTH);

  job_t            slot_r [JOB_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full       = (count_r == (PW+1)'(JOB_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/mqbr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbr_back - byte store and result stream
// Carries out one store access a cycle in job order, unless a result is held
// by out_stall, and drives the registered result channel.
// ----------------------------------------------------------------------------
module mqbr_back #(
  parameter int QUEUE_MEM_BYTES = mqbr_pkg::QUEUE_MEM_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  mqbr_pkg::job_t                job,
  output logic                          job_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mqbr_pkg::STAT_W-1:0]   out_status,
  output logic [mqbr_pkg::BYTE_W-1:0]   out_out_byte,
  output logic [mqbr_pkg::SIZE_W-1:0]   out_fill_count,
  output logic                          out_last
);
  import mqbr_pkg::*;

  localparam int AW = $clog2(QUEUE_MEM_BYTES);

  logic [BYTE_W-1:0] mem [QUEUE_MEM_BYTES];
  logic [BYTE_W-1:0] mem_q_r;
  logic [CNT_W-1:0]  beat_r;
  logic [SIZE_W-1:0] idx_r;
  logic              out_valid_r, out_last_r, out_mem_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SIZE_W-1:0] out_fill_r;

  logic              issue, last_beat;
  logic [SIZE_W-1:0] cur_idx, idx_nxt;
  logic [SIZE_W:0]   idx_inc;
  logic [SUM_W:0]    addr_sum;
  logic [AW-1:0]     addr;

  assign issue     = job_valid && (!out_valid_r || !out_stall);
  assign cur_idx   = (beat_r == '0) ? job.start : idx_r;
  assign idx_inc   = {1'b0, cur_idx} + (SIZE_W+1)'(1);
  assign idx_nxt   = (idx_inc == {1'b0, job.size}) ? '0 : idx_inc[SIZE_W-1:0];
  assign addr_sum  = {1'b0, job.base} + (SUM_W+1)'(cur_idx);
  assign addr      = AW'(addr_sum);
  assign last_beat = (job.kind != JOB_READ) || ((beat_r + CNT_W'(1)) == job.count);
  assign job_pop   = issue && last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r  <= 1'b1;
      beat_r       <= last_beat ? '0 : beat_r + CNT_W'(1);
      idx_r        <= idx_nxt;
      out_status_r <= job.status;
      out_fill_r   <= job.fill;
      out_last_r   <= last_beat;
      out_mem_r    <= (job.kind == JOB_READ);
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Byte store: one access a cycle unless a result is held by out_stall, read data registered.
  always_ff @(posedge clk) begin
    if (issue && (job.kind == JOB_WRITE)) begin
      mem[addr] <= job.data;
    end
    if (issue && (job.kind == JOB_READ)) begin
      mem_q_r <= mem[addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_out_byte   = out_mem_r ? mem_q_r : '0;
  assign out_fill_count = out_fill_r;
  assign out_last       = out_last_r;

endmodule

// ===== tb/sv/tb_multi_queue_byte_ring_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_queue_byte_ring_engine_core - self-checking bench for the byte rings
// Lays out the shared store through the size registers, sends push, pop, peek
// and count commands and checks every result against an in-bench ring model.
// Traffic runs under free-flowing, sender-gap, receiver-stall and mixed flow
// control, across layouts that reach both ends of the size range.
// ----------------------------------------------------------------------------
module tb_multi_queue_byte_ring_engine_core;
  import mqbr_pkg::*;

  localparam int STORE_BYTES  = QUEUE_MEM_BYTES_DEF;
  localparam int POP_LIMIT    = MAX_POP_DEF;
  localparam int RING_COUNT   = NUM_QUEUES_DEF;
  localparam int REG_STRIDE   = 4;     // byte distance between size registers
  localparam int STALL_LIMIT  = 4000;  // cycles without a transfer before giving up
  localparam int SETTLE_TICKS = 6;     // settling margin after the last result
  localparam int PHASE_CMDS   = 40;

  typedef enum int {
    REG_QUEUE_SIZE_0,
    REG_QUEUE_SIZE_1,
    REG_QUEUE_SIZE_2,
    REG_QUEUE_SIZE_3
  } size_reg_t;

  typedef enum int {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [1:0]        qid;
    logic [BYTE_W-1:0] byte_val;
    logic [CNT_W-1:0]  count;
  } ring_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data;
    qsize_t            fill;
    logic              is_last;
  } ring_result_t;

  // Layout 0 is used by the directed commands; the rest feed one random phase
  // each. Between them they hit size one, the largest size, a region ending on
  // the last byte of the store and regions that run past it.
  localparam qsize_t LAYOUTS [6][4] = '{
    '{10'd1,    10'd16,   10'd64,  10'd200},
    '{10'd1023, 10'd5,    10'd0,   10'd8},
    '{10'd300,  10'd400,  10'd323, 10'd1},
    '{10'd3,    10'd2,    10'd8,   10'd5},
    '{10'd0,    10'd1022, 10'd1,   10'd0},
    '{10'd64,   10'd7,    10'd1,   10'd4}
  };
  localparam flow_mode_t PHASE_FLOW [5] = '{
    FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH, FLOW_FREE, FLOW_RECV_STALLS
  };

  logic clk;
  logic rst_n = 1'b0;

  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [1:0]        in_command   = '0;
  logic [1:0]        in_queue_id  = '0;
  logic [BYTE_W-1:0] in_push_byte = '0;
  logic [CNT_W-1:0]  in_pop_count = '0;

  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [BYTE_W-1:0] out_out_byte;
  qsize_t            out_fill_count;
  logic              out_last;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  multi_queue_byte_ring_engine_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_queue_id    (in_queue_id),
    .in_push_byte   (in_push_byte),
    .in_pop_count   (in_pop_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_out_byte   (out_out_byte),
    .out_fill_count (out_fill_count),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ring model state: one byte store shared by all queues, and per queue its
  // size, write index, read index and fill.
  logic [BYTE_W-1:0] ring_store [STORE_BYTES];
  qsize_t            q_size [RING_COUNT];
  qsize_t            q_wr   [RING_COUNT];
  qsize_t            q_rd   [RING_COUNT];
  qsize_t            q_fill [RING_COUNT];

  ring_cmd_t    cmd_backlog [$];       // commands waiting to be offered
  ring_result_t ring_results_due [$];  // results owed by the block, oldest first
  int           plan_fill [RING_COUNT]; // fill as seen by the stimulus planner

  flow_mode_t  flow_mode = FLOW_FREE;
  ring_cmd_t   cur_cmd;
  bit          deep_burst_done = 1'b0;
  int unsigned faults = 0;
  int unsigned cmds_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  // A queue only exists when it has a size and its region ends strictly below
  // the top of the store; base returns where its region starts.
  function automatic bit queue_usable(input int q, output int base);
    base = 0;
    for (int j = 0; j < q; j++) base += q_size[j];
    return q_size[q] != 0 && base + q_size[q] < STORE_BYTES;
  endfunction

  function automatic qsize_t ring_next(input qsize_t idx, input qsize_t size);
    return qsize_t'((int'(idx) + 1) % int'(size));
  endfunction

  // Writing any size register empties every queue.
  function automatic void ring_relayout(input int q, input qsize_t size);
    q_size[q] = size;
    for (int j = 0; j < RING_COUNT; j++) begin
      q_wr[j]      = '0;
      q_rd[j]      = '0;
      q_fill[j]    = '0;
      plan_fill[j] = 0;
    end
  endfunction

  // Works out the results of one accepted command and advances the model.
  function automatic void ring_predict(input ring_cmd_t c);
    ring_result_t r;
    qsize_t       size;
    qsize_t       held;
    qsize_t       rd;
    int           base;
    int           q;
    q    = int'(c.qid);
    size = q_size[q];
    r    = '{status: ST_OFF, data: '0, fill: '0, is_last: 1'b1};
    if (!queue_usable(q, base)) begin
      ring_results_due.push_back(r);
      return;
    end
    held   = q_fill[q];
    r.fill = held;
    r.status = ST_OK;
    case (c.cmd)
      CMD_PUSH: begin
        ring_store[base + int'(q_wr[q])] = c.byte_val;
        q_wr[q] = ring_next(q_wr[q], size);
        // A full queue loses its oldest byte to make room.
        if (held >= size) q_rd[q] = ring_next(q_rd[q], size);
        else held = held + 1'b1;
        q_fill[q] = held;
        r.fill    = held;
        r.status  = (held >= size) ? ST_FULL : ST_OK;
        ring_results_due.push_back(r);
      end
      CMD_POP: begin
        if (c.count == 0) begin
          ring_results_due.push_back(r);
        end else if (int'(c.count) > POP_LIMIT || held < c.count) begin
          r.status = ST_SHORT;
          ring_results_due.push_back(r);
        end else begin
          rd     = q_rd[q];
          r.fill = qsize_t'(int'(held) - int'(c.count));
          for (int k = 0; k < int'(c.count); k++) begin
            r.data    = ring_store[base + int'(rd)];
            r.is_last = (k == int'(c.count) - 1);
            ring_results_due.push_back(r);
            rd = ring_next(rd, size);
          end
          q_rd[q]   = rd;
          q_fill[q] = r.fill;
        end
      end
      CMD_PEEK: begin
        if (held == 0) r.status = ST_SHORT;
        else r.data = ring_store[base + int'(q_rd[q])];
        ring_results_due.push_back(r);
      end
      default: ring_results_due.push_back(r);
    endcase
  endfunction

  // Queues one command and keeps the planner's view of the fill in step, so
  // that pops can be sized to succeed.
  function automatic void plan_add(input cmd_t cmd, input int q, input int b, input int n);
    ring_cmd_t c;
    int        base;
    c.cmd      = cmd;
    c.qid      = 2'(q);
    c.byte_val = 8'(b);
    c.count    = 7'(n);
    cmd_backlog.push_back(c);
    if (queue_usable(q, base)) begin
      if (cmd == CMD_PUSH && plan_fill[q] < int'(q_size[q])) plan_fill[q]++;
      else if (cmd == CMD_POP && n >= 1 && n <= POP_LIMIT && n <= plan_fill[q])
        plan_fill[q] -= n;
    end
  endfunction

  // Random phase: mostly bursts of pushes followed by a pop that the queue
  // can satisfy, with some raw commands on any queue and any field values.
  // At most one burst in the run fills a queue by the largest pop and empties it again.
  function automatic void plan_phase(input int budget);
    int q;
    int m;
    int k;
    int base;
    bit deep;
    while (cmd_backlog.size() < budget) begin
      q = $urandom_range(RING_COUNT - 1);
      if (!queue_usable(q, base) || $urandom_range(99) < 20) begin
        plan_add(cmd_t'($urandom_range(3)), q, $urandom_range(255), $urandom_range(127));
      end else begin
        deep = !deep_burst_done && q_size[q] >= POP_LIMIT && $urandom_range(3) == 0;
        deep_burst_done |= deep;
        m = deep ? POP_LIMIT : $urandom_range(1, 6);
        repeat (m) plan_add(CMD_PUSH, q, $urandom_range(255), 0);
        if ($urandom_range(3) == 0) plan_add(CMD_PEEK, q, 0, 0);
        if ($urandom_range(4) == 0) plan_add(CMD_COUNT, q, 0, 0);
        k = (plan_fill[q] < POP_LIMIT) ? plan_fill[q] : POP_LIMIT;
        plan_add(CMD_POP, q, 0, deep ? POP_LIMIT : $urandom_range(1, k));
      end
    end
  endfunction

  // Decides, cycle by cycle, whether one side of the stream holds back.
  function automatic bit flow_hold(input bit sender_side);
    case (flow_mode)
      FLOW_SEND_GAPS:   return sender_side && $urandom_range(99) < 79;
      FLOW_RECV_STALLS: return !sender_side && $urandom_range(99) < 79;
      FLOW_BOTH:        return $urandom_range(99) < 34;
      default:          return 1'b0;
    endcase
  endfunction

  // One register access: a setup cycle and an access cycle. The write lands,
  // and read data is taken, at the edge that closes the access cycle.
  task automatic cfg_access(input size_reg_t r, input bit wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(REG_STRIDE * int'(r));
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes all four size registers of one layout and reads each one back.
  task automatic program_layout(input int layout);
    size_reg_t         r;
    logic [APB_DW-1:0] rb;
    r = r.first();
    repeat (SIZE_REGS) begin
      cfg_access(r, 1'b1, APB_DW'(LAYOUTS[layout][r]), rb);
      ring_relayout(int'(r), LAYOUTS[layout][r]);
      cfg_access(r, 1'b0, '0, rb);
      if (rb[SIZE_W-1:0] !== LAYOUTS[layout][r]) begin
        $error("%s readback: expected %0d, got %0d", r.name(), LAYOUTS[layout][r],
               rb[SIZE_W-1:0]);
        faults++;
      end
      r = r.next();
    end
  endtask

  // Waits until every command has been taken and every result has arrived,
  // then lets the pipeline settle before the registers are touched again.
  // The check is made at falling edges, once the clocked blocks have settled.
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || ring_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Command driver. A transfer happens at an edge where in_valid is high and
  // in_stall is low; the model is advanced on that transfer. A new command is
  // only presented once the previous one has gone, so a stalled command keeps
  // its fields untouched.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ring_predict(cur_cmd);
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && !flow_hold(1'b1)) begin
          cur_cmd = cmd_backlog.pop_front();
          in_command   <= cur_cmd.cmd;
          in_queue_id  <= cur_cmd.qid;
          in_push_byte <= cur_cmd.byte_val;
          in_pop_count <= cur_cmd.count;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every result transfer is matched against the oldest
  // result still owed, field by field.
  always @(posedge clk) begin
    ring_result_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (ring_results_due.size() == 0) begin
          $error("result with none owed: status %0d, out_byte 0x%02h, fill_count %0d",
                 out_status, out_out_byte, out_fill_count);
          faults++;
        end else begin
          due = ring_results_due.pop_front();
          if (out_status !== due.status) begin
            $error("status: expected %s, got %0d", due.status.name(), out_status);
            faults++;
          end
          if (out_out_byte !== due.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", due.data, out_out_byte);
            faults++;
          end
          if (out_fill_count !== due.fill) begin
            $error("fill_count: expected %0d, got %0d", due.fill, out_fill_count);
            faults++;
          end
          if (out_last !== due.is_last) begin
            $error("last: expected %0b, got %0b", due.is_last, out_last);
            faults++;
          end
        end
      end
      out_stall <= flow_hold(1'b0);
    end
  end

  // Watchdog: counts cycles with work outstanding but no transfer on either
  // channel. Stall streaks under the heaviest flow control stay far below it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cmd_backlog.size() == 0 && !in_valid && ring_results_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: %0d results still owed", ring_results_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned p;
    for (int j = 0; j < RING_COUNT; j++) ring_relayout(j, '0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset every size is zero, so every queue is disabled.
    plan_add(CMD_PUSH,  0, 8'hFF, 0);
    plan_add(CMD_POP,   1, 0, 1);
    plan_add(CMD_PEEK,  2, 0, 0);
    plan_add(CMD_COUNT, 3, 0, 0);
    drain();

    // Directed commands on sizes 1, 16, 64 and 200.
    program_layout(0);
    plan_add(CMD_PEEK,  1, 0, 0);          // peek on an empty queue
    plan_add(CMD_POP,   1, 0, 1);          // pop with too few bytes
    plan_add(CMD_COUNT, 1, 0, 0);
    plan_add(CMD_POP,   1, 0, 0);          // pop of nothing
    plan_add(CMD_POP,   1, 0, 127);        // largest count the field holds
    plan_add(CMD_POP,   1, 0, POP_LIMIT + 1);
    plan_add(CMD_PUSH,  0, 8'hFF, 0);      // one-byte queue fills at once
    plan_add(CMD_PUSH,  0, 8'h00, 0);      // and then overwrites its only byte
    plan_add(CMD_PEEK,  0, 0, 0);
    plan_add(CMD_POP,   0, 0, 1);
    plan_add(CMD_PUSH,  1, 8'hA5, 0);
    plan_add(CMD_PUSH,  1, 8'h5A, 0);
    plan_add(CMD_PUSH,  1, 8'h01, 0);
    plan_add(CMD_PUSH,  1, 8'h80, 0);
    plan_add(CMD_PEEK,  1, 0, 0);
    plan_add(CMD_COUNT, 1, 0, 0);
    plan_add(CMD_POP,   1, 0, 4);
    plan_add(CMD_PUSH,  3, 8'h7F, 0);
    plan_add(CMD_PUSH,  2, 8'hC3, 0);
    plan_add(CMD_POP,   3, 0, POP_LIMIT);  // largest legal pop, not enough bytes
    plan_add(CMD_POP,   3, 0, 1);
    plan_add(CMD_PEEK,  2, 0, 0);
    drain();

    // Random phases, each on a fresh layout and its own flow control.
    for (p = 0; p < 5; p++) begin
      program_layout(p + 1);
      flow_mode = PHASE_FLOW[p];
      plan_phase(PHASE_CMDS);
      drain();
    end
    flow_mode = FLOW_FREE;
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Checked %0d commands and %0d results on six store layouts,", cmds_accepted,
             results_seen);
    $display("under free, sender-gap, receiver-stall and mixed flow control.");
    if (faults == 0 && ring_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
